// File: hdl/integer_printf_formatter_assert.svh
// Assertion macros shared by the formatter RTL
`ifndef INTEGER_PRINTF_FORMATTER_ASSERT_SVH
`define INTEGER_PRINTF_FORMATTER_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define IPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define IPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ipf_pkg.sv
// Types, constants and helper functions of the integer printf formatter
package ipf_pkg;

	localparam int MAX_WIDTH_DEF  = 63;
	localparam int VALUE_BITS_DEF = 32;

	// conversion codes
	localparam logic [1:0] CONV_SDEC = 2'd0;
	localparam logic [1:0] CONV_UDEC = 2'd1;
	localparam logic [1:0] CONV_LHEX = 2'd2;
	localparam logic [1:0] CONV_UHEX = 2'd3;

	// ASCII
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// digit buffer
	localparam int DIGIT_SLOTS = 16;
	localparam int DIGIT_IDX_W = 4;

	// divide by ten: q = (v * RECIP10) >> RECIP10_SHIFT, exact for v < 2**32
	localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
	localparam int          RECIP10_SHIFT = 35;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_HEX,
		ST_PLAN,
		ST_LEAD,
		ST_SIGN,
		ST_ZERO,
		ST_DIGIT,
		ST_TRAIL
	} state_t;

	typedef struct packed {
		logic load;   // capture the reciprocal product
		logic hex;    // divide by sixteen instead of ten
	} unit_ctl_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (d < 4'd10)
			return CH_ZERO + {4'h0, d};
		else
			return base + {4'h0, d} - 8'd10;
	endfunction

endpackage

// File: hdl/ipf_digit_unit.sv
// Shared digit unit: one division by ten or sixteen with remainder
module ipf_digit_unit #(
	parameter int VALUE_BITS = ipf_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  ipf_pkg::unit_ctl_t    ctl,
	input  logic [VALUE_BITS-1:0] val,
	output logic [VALUE_BITS-1:0] quot,
	output logic [3:0]            digit
);

	localparam int PW = VALUE_BITS + 32;

	logic [PW-1:0]         prod_q;
	logic [VALUE_BITS-1:0] dec_quot;
	logic [VALUE_BITS-1:0] dec_rem;

	// hold the reciprocal product for the remainder cycle
	always_ff @(posedge clk) begin
		if (ctl.load)
			prod_q <= {{32{1'b0}}, val} * {{VALUE_BITS{1'b0}}, ipf_pkg::RECIP10};
	end

	assign dec_quot = VALUE_BITS'(prod_q >> ipf_pkg::RECIP10_SHIFT);
	assign dec_rem  = val - ((dec_quot << 3) + (dec_quot << 1));

	assign quot  = ctl.hex ? (val >> 4) : dec_quot;
	assign digit = ctl.hex ? val[3:0] : dec_rem[3:0];

endmodule

// File: hdl/integer_printf_formatter.sv
// Top level of the integer printf formatter (%d, %u, %x, %X)
//
// Input channel (in_valid / in_stall): one word carries a value with its
// conversion, flags, field width and precision. in_stall is high whenever
// an item is in progress; one item is taken at a time.
// Output channel (out_valid / out_stall): one word per ASCII character, in
// print order: leading spaces, sign, zeros, digits, trailing spaces. last
// marks the final character of an item; total_count is the running count of
// characters including this one, wrapping at 32 bits.
// Decimal conversion runs each digit through the shared digit unit as a
// reciprocal multiply, then a remainder; hex takes each digit straight from
// the low four bits. Each print segment before the last character closes
// with a step that emits nothing, and the item ends on its last character.
// A zero value with an explicit zero precision, no width and no plus sign
// gives no words.
// Reset clears the running count and the output valid flag; the block comes
// up idle and ready. While the receiver stalls, the character register holds
// and the sequencer waits; the next item may be accepted while the last
// character of the previous one is still waiting.
module integer_printf_formatter #(
	parameter int MAX_WIDTH  = ipf_pkg::MAX_WIDTH_DEF,
	parameter int VALUE_BITS = ipf_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [1:0]  conversion,
	input  logic        left_justify,
	input  logic        zero_pad,
	input  logic        plus_flag,
	input  logic [5:0]  field_width,
	input  logic        precision_given,
	input  logic [5:0]  min_digits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last,
	output logic [31:0] total_count
);

	`include "integer_printf_formatter_assert.svh"

	localparam int WW = $clog2(MAX_WIDTH + 1);  // width of a character count
	localparam int PW = WW + 1;                 // headroom for layout sums
	localparam int DW = ipf_pkg::DIGIT_IDX_W;

	ipf_pkg::state_t state_q, state_d;

	// item registers
	logic [VALUE_BITS-1:0] val_q;
	logic                  upper_q;
	logic                  ljust_q;
	logic                  zpad_q;
	logic                  pgiven_q;
	logic [WW-1:0]         fw_q;
	logic [WW-1:0]         prec_q;
	logic                  sign_q;
	logic [7:0]            sign_ch_q;
	logic [DW-1:0]         nd_q;
	logic [3:0]            dig_q [ipf_pkg::DIGIT_SLOTS];
	logic [WW-1:0]         lead_q;
	logic [WW-1:0]         zeros_q;
	logic [WW-1:0]         trail_q;

	// sequencing
	logic [WW-1:0]         rem_q;
	logic [WW-1:0]         cnt_q;

	// output register
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic [31:0]           total_q;

	// accept-side decode
	logic                  in_take;
	logic [VALUE_BITS-1:0] v_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [WW-1:0]         fw_in;
	logic [WW-1:0]         prec_in;
	logic                  skip_in;

	// digit unit
	ipf_pkg::unit_ctl_t    unit_ctl;
	logic [VALUE_BITS-1:0] unit_quot;
	logic [3:0]            unit_digit;

	// layout
	logic [PW-1:0]         nd_ext, prec_ext, fw_ext;
	logic [PW-1:0]         z0, b0, z1, b1, pad, n_all;
	logic                  zfill;

	// emit
	logic                  in_emit;
	logic [WW-1:0]         seg_len;
	logic                  seg_done;
	logic                  emit_go;
	logic [7:0]            emit_char;
	logic [DW-1:0]         dig_idx;

	ipf_digit_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_digit (
		.clk   (clk),
		.ctl   (unit_ctl),
		.val   (val_q),
		.quot  (unit_quot),
		.digit (unit_digit)
	);

	// Decode the incoming word: magnitude, sign, saturated width and precision.
	always_comb begin
		v_in    = value[VALUE_BITS-1:0];
		neg_in  = (conversion == ipf_pkg::CONV_SDEC) && v_in[VALUE_BITS-1];
		mag_in  = neg_in ? (~v_in + 1'b1) : v_in;
		fw_in   = (field_width > 6'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(field_width);
		prec_in = (min_digits > 6'(MAX_WIDTH - 1)) ? WW'(MAX_WIDTH - 1) : WW'(min_digits);
		// zero value under an explicit zero precision prints no digits
		skip_in = precision_given && (min_digits == 6'd0) && (mag_in == '0);
	end

	// Lay out the field once the digit count is known.
	always_comb begin
		nd_ext   = PW'(nd_q);
		prec_ext = PW'(prec_q);
		fw_ext   = PW'(fw_q);
		z0       = (pgiven_q && (prec_ext > nd_ext)) ? (prec_ext - nd_ext) : '0;
		b0       = PW'(sign_q) + z0 + nd_ext;
		zfill    = zpad_q && !ljust_q && !pgiven_q && (fw_ext > b0);
		z1       = zfill ? (z0 + fw_ext - b0) : z0;
		b1       = zfill ? fw_ext : b0;
		pad      = (fw_ext > b1) ? (fw_ext - b1) : '0;
		n_all    = pad + b1;
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall     = (state_q != ipf_pkg::ST_IDLE);
		in_take      = in_valid && (state_q == ipf_pkg::ST_IDLE);
		unit_ctl.load = (state_q == ipf_pkg::ST_DIV);
		unit_ctl.hex  = (state_q == ipf_pkg::ST_HEX);
		in_emit      = state_q inside {ipf_pkg::ST_LEAD, ipf_pkg::ST_SIGN, ipf_pkg::ST_ZERO,
		                               ipf_pkg::ST_DIGIT, ipf_pkg::ST_TRAIL};
		dig_idx      = nd_q - DW'(1) - cnt_q[DW-1:0];
		case (state_q)
			ipf_pkg::ST_LEAD: begin
				seg_len   = lead_q;
				emit_char = ipf_pkg::CH_SPACE;
			end
			ipf_pkg::ST_SIGN: begin
				seg_len   = WW'(sign_q);
				emit_char = sign_ch_q;
			end
			ipf_pkg::ST_ZERO: begin
				seg_len   = zeros_q;
				emit_char = ipf_pkg::CH_ZERO;
			end
			ipf_pkg::ST_DIGIT: begin
				seg_len   = WW'(nd_q);
				emit_char = ipf_pkg::digit_char(dig_q[dig_idx], upper_q);
			end
			ipf_pkg::ST_TRAIL: begin
				seg_len   = trail_q;
				emit_char = ipf_pkg::CH_SPACE;
			end
			default: begin
				seg_len   = '0;
				emit_char = ipf_pkg::CH_SPACE;
			end
		endcase
		seg_done = in_emit && (cnt_q == seg_len);
		emit_go  = in_emit && !seg_done && (!out_valid_q || !out_stall);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ipf_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (skip_in)
						state_d = ipf_pkg::ST_PLAN;
					else if (conversion[1])
						state_d = ipf_pkg::ST_HEX;
					else
						state_d = ipf_pkg::ST_DIV;
				end
			end
			ipf_pkg::ST_DIV: state_d = ipf_pkg::ST_REM;
			ipf_pkg::ST_REM: state_d = (unit_quot == '0) ? ipf_pkg::ST_PLAN : ipf_pkg::ST_DIV;
			ipf_pkg::ST_HEX: state_d = (unit_quot == '0) ? ipf_pkg::ST_PLAN : ipf_pkg::ST_HEX;
			ipf_pkg::ST_PLAN: state_d = (n_all == '0) ? ipf_pkg::ST_IDLE : ipf_pkg::ST_LEAD;
			ipf_pkg::ST_LEAD, ipf_pkg::ST_SIGN, ipf_pkg::ST_ZERO,
			ipf_pkg::ST_DIGIT, ipf_pkg::ST_TRAIL: begin
				if (emit_go && (rem_q == WW'(1))) begin
					// final character loaded: drop back to idle
					state_d = ipf_pkg::ST_IDLE;
				end else if (seg_done) begin
					case (state_q)
						ipf_pkg::ST_LEAD:  state_d = ipf_pkg::ST_SIGN;
						ipf_pkg::ST_SIGN:  state_d = ipf_pkg::ST_ZERO;
						ipf_pkg::ST_ZERO:  state_d = ipf_pkg::ST_DIGIT;
						ipf_pkg::ST_DIGIT: state_d = ipf_pkg::ST_TRAIL;
						default:           state_d = ipf_pkg::ST_IDLE;
					endcase
				end
			end
			default: state_d = ipf_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipf_pkg::ST_IDLE;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ipf_pkg::ST_PLAN) begin
				rem_q <= WW'(n_all);
				cnt_q <= '0;
			end else begin
				if (emit_go)
					rem_q <= rem_q - WW'(1);
				if (seg_done)
					cnt_q <= '0;
				else if (emit_go)
					cnt_q <= cnt_q + WW'(1);
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
				total_q     <= total_q + 32'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and character registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			val_q     <= mag_in;
			upper_q   <= (conversion == ipf_pkg::CONV_UHEX);
			ljust_q   <= left_justify;
			zpad_q    <= zero_pad;
			pgiven_q  <= precision_given;
			fw_q      <= fw_in;
			prec_q    <= prec_in;
			sign_q    <= neg_in || ((conversion == ipf_pkg::CONV_SDEC) && plus_flag);
			sign_ch_q <= neg_in ? ipf_pkg::CH_MINUS : ipf_pkg::CH_PLUS;
			nd_q      <= '0;
		end
		if ((state_q == ipf_pkg::ST_REM) || (state_q == ipf_pkg::ST_HEX)) begin
			// store the digit, least significant first, and advance
			dig_q[nd_q] <= unit_digit;
			val_q       <= unit_quot;
			nd_q        <= nd_q + DW'(1);
		end
		if (state_q == ipf_pkg::ST_PLAN) begin
			lead_q  <= ljust_q ? '0 : WW'(pad);
			trail_q <= ljust_q ? WW'(pad) : '0;
			zeros_q <= WW'(z1);
		end
		if (emit_go) begin
			char_q <= emit_char;
			last_q <= (rem_q == WW'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign last        = last_q;
	assign total_count = total_q;

	`IPF_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_take, in_stall, "accepted item did not raise stall")
	`IPF_ASSERT_NEXT(a_count_step, clk, arst_n, emit_go, total_count == $past(total_count) + 32'd1, "running count did not advance by one")
	`IPF_ASSERT_NOW(a_idle_drained, clk, arst_n, state_q == ipf_pkg::ST_IDLE, rem_q == '0, "idle with characters still owed")

endmodule
